// ===== design/sil_pkg.sv =====
`default_nettype none

package sil_pkg;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_FIND   = 3'd1;
  localparam logic [2:0] OP_MERGE  = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_IDX = 2'd2;

  localparam logic [15:0] MERGE_GAP_RESET = 16'd819;
  localparam logic [5:0]  REMOVED_MAX     = 6'd63;
  localparam logic [6:0]  COUNT_MAX       = 7'd127;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_WR,
    S_FIND,
    S_MERGE,
    S_READ,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== design/sorted_intercept_list.sv =====
`default_nettype none

// Sorted intercept table: up to DEPTH entries (edge id, signed Q20.12 distance) kept in
// ascending distance order in one single-port-write, registered-read memory. One transaction
// in gives one transaction out. Insert walks down from the last entry, shifting each larger
// entry up one place before writing the new one; find scans up from entry 0 and stops on a
// hit; merge scans every entry; read fetches one entry; clear and unused codes do no walk. Every walk visits one memory
// entry per cycle, so the memory port sets the rate. A new transaction is taken while a
// finished result still waits at the output. merge_gap is written through the cfg_ channel,
// which is always ready.
module sorted_intercept_list
  import sil_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int EDGE_BITS = 16,
  parameter int DIST_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_merge_gap,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_op,
  input  wire logic [15:0]        in_edge_id,
  input  wire logic signed [31:0] in_distance,
  input  wire logic [5:0]         in_read_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic                    out_found,
  output logic [6:0]              out_entry_count,
  output logic [5:0]              out_removed_count,
  output logic [15:0]             out_read_edge,
  output logic signed [31:0]      out_read_distance
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = EDGE_BITS + DIST_BITS;
  localparam int GW = DIST_BITS + 2;

  logic [MW-1:0] mem [DEPTH];

  state_t state_r, state_nxt;

  logic [15:0]                 gap_r;
  logic [2:0]                  op_r, op_nxt;
  logic [EDGE_BITS-1:0]        edge_r, edge_nxt;
  logic signed [DIST_BITS-1:0] dist_r, dist_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        found_r, found_nxt;
  logic [5:0]                  rm_r, rm_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic [CW-1:0]               kept_r, kept_nxt;
  logic signed [DIST_BITS-1:0] kept_dist_r, kept_dist_nxt;
  logic [15:0]                 rdo_edge_r, rdo_edge_nxt;
  logic [31:0]                 rdo_dist_r, rdo_dist_nxt;
  logic [MW-1:0]               rd_data_r;

  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic                        out_found_r;
  logic [6:0]                  out_count_r;
  logic [5:0]                  out_rm_r;
  logic [15:0]                 out_edge_r;
  logic [31:0]                 out_dist_r;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [MW-1:0] mem_wd;

  logic in_fire, out_load;

  // input and memory field views
  logic [EDGE_BITS+15:0]        in_edge_w;
  logic [EDGE_BITS-1:0]         in_edge_s;
  logic signed [DIST_BITS+31:0] in_dist_w;
  logic signed [DIST_BITS-1:0]  in_dist_s;
  logic [CW+5:0]                ridx_w, cnt_w6;
  logic [EDGE_BITS-1:0]         rd_edge;
  logic signed [DIST_BITS-1:0]  rd_dist;
  logic [EDGE_BITS+15:0]        rd_edge_w;
  logic [DIST_BITS+31:0]        rd_dist_w;
  logic [CW+6:0]                cnt_w7;

  logic [CW-1:0]        cnt_m1, pos_m1, pos_m2, idx_p1, kept_p1;
  logic signed [GW-1:0] diff_s, gap_s;
  logic                 cmp_less, find_hit, merge_drop, scan_last, idx_beyond, tbl_full;

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  assign in_edge_w = {{EDGE_BITS{1'b0}}, in_edge_id};
  assign in_edge_s = in_edge_w[EDGE_BITS-1:0];
  assign in_dist_w = (DIST_BITS + 32)'(in_distance);
  assign in_dist_s = in_dist_w[DIST_BITS-1:0];
  assign ridx_w    = (CW + 6)'(in_read_index);
  assign cnt_w6    = (CW + 6)'(cnt_r);

  assign rd_edge   = rd_data_r[MW-1:DIST_BITS];
  assign rd_dist   = rd_data_r[DIST_BITS-1:0];
  assign rd_edge_w = {16'd0, rd_edge};
  assign rd_dist_w = {32'd0, rd_dist};
  assign cnt_w7    = (CW + 7)'(cnt_r);

  assign cnt_m1  = cnt_r - CW'(1);
  assign pos_m1  = pos_r - CW'(1);
  assign pos_m2  = pos_r - CW'(2);
  assign idx_p1  = idx_r + CW'(1);
  assign kept_p1 = kept_r + CW'(1);

  assign diff_s = GW'(rd_dist) - GW'(kept_dist_r);
  assign gap_s  = $signed({{(GW - 16){1'b0}}, gap_r});

  assign cmp_less   = dist_r < rd_dist;
  assign find_hit   = rd_edge == edge_r;
  assign merge_drop = (kept_r != '0) && (diff_s <= gap_s);
  assign scan_last  = idx_p1 == cnt_r;
  assign idx_beyond = ridx_w >= cnt_w6;
  assign tbl_full   = cnt_r == CW'(DEPTH);

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_INSERT: begin
              if (tbl_full) state_nxt = S_RESP;
              else if (cnt_r == '0) state_nxt = S_INS_WR;
              else state_nxt = S_INS_CMP;
            end
            OP_FIND:  state_nxt = (cnt_r == '0) ? S_RESP : S_FIND;
            OP_MERGE: state_nxt = (cnt_r == '0) ? S_RESP : S_MERGE;
            OP_READ:  state_nxt = idx_beyond ? S_RESP : S_READ;
            default:  state_nxt = S_RESP;
          endcase
        end
      end
      S_INS_CMP: begin
        if (!cmp_less) state_nxt = S_RESP;
        else if (pos_m1 == '0) state_nxt = S_INS_WR;
      end
      S_INS_WR: state_nxt = S_RESP;
      S_FIND:   if (find_hit || scan_last) state_nxt = S_RESP;
      S_MERGE:  if (scan_last) state_nxt = S_RESP;
      S_READ:   state_nxt = S_RESP;
      S_RESP:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt        = op_r;
    edge_nxt      = edge_r;
    dist_nxt      = dist_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    rm_nxt        = rm_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    kept_nxt      = kept_r;
    kept_dist_nxt = kept_dist_r;
    rdo_edge_nxt  = rdo_edge_r;
    rdo_dist_nxt  = rdo_dist_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt       = in_op;
          edge_nxt     = in_edge_s;
          dist_nxt     = in_dist_s;
          status_nxt   = ST_OK;
          found_nxt    = 1'b0;
          rm_nxt       = '0;
          rdo_edge_nxt = '0;
          rdo_dist_nxt = '0;
          idx_nxt      = '0;
          kept_nxt     = '0;
          pos_nxt      = cnt_r;
          case (in_op)
            OP_INSERT: begin
              if (tbl_full) begin
                status_nxt = ST_FULL;
              end else if (cnt_r != '0) begin
                mem_re = 1'b1;
                mem_ra = cnt_m1[AW-1:0];
              end
            end
            OP_FIND, OP_MERGE: begin
              mem_re = 1'b1;
              mem_ra = '0;
            end
            OP_CLEAR: cnt_nxt = '0;
            OP_READ: begin
              if (idx_beyond) begin
                status_nxt = ST_BAD_IDX;
              end else begin
                mem_re = 1'b1;
                mem_ra = ridx_w[AW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        mem_wa = pos_r[AW-1:0];
        if (cmp_less) begin
          // shift the larger entry up one place and look one lower
          mem_wd  = rd_data_r;
          pos_nxt = pos_m1;
          mem_re  = 1'b1;
          mem_ra  = pos_m2[AW-1:0];
        end else begin
          mem_wd  = {edge_r, dist_r};
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_INS_WR: begin
        mem_we  = 1'b1;
        mem_wa  = pos_r[AW-1:0];
        mem_wd  = {edge_r, dist_r};
        cnt_nxt = cnt_r + CW'(1);
      end
      S_FIND: begin
        if (find_hit) found_nxt = 1'b1;
        idx_nxt = idx_p1;
        mem_re  = 1'b1;
        mem_ra  = idx_p1[AW-1:0];
      end
      S_MERGE: begin
        // compaction writes land at or below the entry just read
        if (merge_drop) begin
          rm_nxt = (rm_r == REMOVED_MAX) ? rm_r : rm_r + 6'd1;
        end else begin
          mem_we        = 1'b1;
          mem_wa        = kept_r[AW-1:0];
          mem_wd        = rd_data_r;
          kept_nxt      = kept_p1;
          kept_dist_nxt = rd_dist;
        end
        if (scan_last) cnt_nxt = merge_drop ? kept_r : kept_p1;
        idx_nxt = idx_p1;
        mem_re  = 1'b1;
        mem_ra  = idx_p1[AW-1:0];
      end
      S_READ: begin
        rdo_edge_nxt = rd_edge_w[15:0];
        rdo_dist_nxt = rd_dist_w[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      gap_r       <= MERGE_GAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) gap_r <= cfg_merge_gap;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    edge_r      <= edge_nxt;
    dist_r      <= dist_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    rm_r        <= rm_nxt;
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    kept_r      <= kept_nxt;
    kept_dist_r <= kept_dist_nxt;
    rdo_edge_r  <= rdo_edge_nxt;
    rdo_dist_r  <= rdo_dist_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_count_r  <= (cnt_w7 > (CW + 7)'(COUNT_MAX)) ? COUNT_MAX : cnt_w7[6:0];
      out_rm_r     <= rm_r;
      out_edge_r   <= rdo_edge_r;
      out_dist_r   <= rdo_dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found         = out_found_r;
  assign out_entry_count   = out_count_r;
  assign out_removed_count = out_rm_r;
  assign out_read_edge     = out_edge_r;
  assign out_read_distance = out_dist_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !mem_we)
    else $error("memory write outside a walk");

  a_merge_kept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MERGE |-> kept_r <= idx_r)
    else $error("merge write overtook the scan");

  a_ins_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS_CMP |-> (pos_r != '0 && pos_r <= cnt_r && !tbl_full))
    else $error("insert position out of range");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && op_r == OP_CLEAR) |-> cnt_r == '0)
    else $error("clear left entries behind");

endmodule

`default_nettype wire

// ===== tb/intercept_list_checker.sv =====
`default_nettype none

module intercept_list_checker
  import sil_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [15:0]        cfg_merge_gap,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [2:0]         in_op,
  input  wire logic [15:0]        in_edge_id,
  input  wire logic signed [31:0] in_distance,
  input  wire logic [5:0]         in_read_index,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [1:0]         out_status,
  input  wire logic               out_found,
  input  wire logic [6:0]         out_entry_count,
  input  wire logic [5:0]         out_removed_count,
  input  wire logic [15:0]        out_read_edge,
  input  wire logic signed [31:0] out_read_distance,
  output int                      mismatches,
  output int                      outstanding
);

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [6:0]         count;
    logic [5:0]         removed;
    logic [15:0]        redge;
    logic signed [31:0] rdist;
  } result_t;

  logic [15:0]        edge_tab [DEPTH];
  logic signed [31:0] dist_tab [DEPTH];
  int                 tally;
  logic [15:0]        gap_now;
  result_t            awaited_results [$];
  result_t            got;
  result_t            want;
  int                 fail_total = 0;
  int                 shown = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    tally       = 0;
    gap_now     = MERGE_GAP_RESET;
  end

  function automatic result_t apply_intercept_op(input logic [2:0] op,
                                                 input logic [15:0] edge_id,
                                                 input logic signed [31:0] dist_in,
                                                 input logic [5:0] idx);
    result_t r;
    int      pos;
    int      k;
    int      kept;
    int      dropped;
    longint  spread;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (tally >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // lands after every entry with a distance not above its own
          pos = tally;
          while (pos > 0 && dist_in < dist_tab[pos-1]) pos--;
          for (k = tally; k > pos; k--) begin
            edge_tab[k] = edge_tab[k-1];
            dist_tab[k] = dist_tab[k-1];
          end
          edge_tab[pos] = edge_id;
          dist_tab[pos] = dist_in;
          tally++;
        end
      end
      OP_FIND: begin
        for (k = 0; k < tally; k++)
          if (edge_tab[k] == edge_id) r.found = 1'b1;
      end
      OP_MERGE: begin
        kept    = 0;
        dropped = 0;
        for (k = 0; k < tally; k++) begin
          spread = (kept > 0) ? longint'(dist_tab[k]) - longint'(dist_tab[kept-1]) : 0;
          if (kept > 0 && spread <= longint'(gap_now)) begin
            dropped++;
          end else begin
            edge_tab[kept] = edge_tab[k];
            dist_tab[kept] = dist_tab[k];
            kept++;
          end
        end
        tally     = kept;
        r.removed = (dropped > int'(REMOVED_MAX)) ? REMOVED_MAX : 6'(dropped);
      end
      OP_CLEAR: tally = 0;
      OP_READ: begin
        if (int'(idx) >= tally) begin
          r.status = ST_BAD_IDX;
        end else begin
          r.redge = edge_tab[idx];
          r.rdist = dist_tab[idx];
        end
      end
      default: ;
    endcase
    r.count = 7'(tally);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tally   = 0;
      gap_now = MERGE_GAP_RESET;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_status, out_found, out_entry_count, out_removed_count,
               out_read_edge, out_read_distance};
        if (awaited_results.size() == 0) begin
          fail_total++;
          if (shown < 10) begin
            shown++;
            $display("unexpected result transaction: status %0d count %0d", got.status,
                     got.count);
          end
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            fail_total++;
            if (shown < 10) begin
              shown++;
              $display("result mismatch: expected st %0d fnd %0d cnt %0d rem %0d edge %h dist %0d",
                       want.status, want.found, want.count, want.removed, want.redge,
                       want.rdist);
              $display("                 actual   st %0d fnd %0d cnt %0d rem %0d edge %h dist %0d",
                       got.status, got.found, got.count, got.removed, got.redge, got.rdist);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) gap_now = cfg_merge_gap;
      if (in_valid && in_ready)
        awaited_results.push_back(apply_intercept_op(in_op, in_edge_id, in_distance,
                                                     in_read_index));
    end
    mismatches  <= fail_total;
    outstanding <= awaited_results.size();
  end

endmodule

`default_nettype wire

// ===== tb/sorted_intercept_list_test.sv =====
`default_nettype none

module sorted_intercept_list_test;
  import sil_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_WAIT     = 11;
  localparam int HOLD_CYCLES  = 160;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 90;
  localparam int FILL_ITEMS   = 70;
  localparam int DEPTH        = 64;

  localparam logic [2:0]         OP_CODE_TOP  = 3'd7;
  localparam logic [15:0]        GAP_NONE     = 16'h0000;
  localparam logic [15:0]        GAP_WIDEST   = 16'hFFFF;
  localparam logic signed [31:0] DIST_LOWEST  = 32'sh8000_0000;
  localparam logic signed [31:0] DIST_HIGHEST = 32'sh7FFF_FFFF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_merge_gap = MERGE_GAP_RESET;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_op = OP_INSERT;
  logic [15:0]        in_edge_id = '0;
  logic signed [31:0] in_distance = '0;
  logic [5:0]         in_read_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic               out_found;
  logic [6:0]         out_entry_count;
  logic [5:0]         out_removed_count;
  logic [15:0]        out_read_edge;
  logic signed [31:0] out_read_distance;

  int                 mismatches;
  int                 outstanding;
  int                 cycles = 0;
  bit                 calm = 1'b0;
  int                 holds_asked = 0;
  int                 holds_done = 0;
  logic [15:0]        recent_edges [16] = '{default: '0};
  int                 recent_slot = 0;
  logic signed [31:0] cluster_base = '0;

  always #HALF_PERIOD clk = ~clk;

  sorted_intercept_list #(.DEPTH(DEPTH)) uut (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_merge_gap,
    .in_valid, .in_ready, .in_op, .in_edge_id, .in_distance, .in_read_index,
    .out_valid, .out_ready, .out_status, .out_found, .out_entry_count,
    .out_removed_count, .out_read_edge, .out_read_distance
  );

  intercept_list_checker #(.DEPTH(DEPTH)) list_chk (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_merge_gap,
    .in_valid, .in_ready, .in_op, .in_edge_id, .in_distance, .in_read_index,
    .out_valid, .out_ready, .out_status, .out_found, .out_entry_count,
    .out_removed_count, .out_read_edge, .out_read_distance,
    .mismatches, .outstanding
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random back-pressure, plus the odd long hold-off on request
  initial begin
    int pause;
    forever begin
      if (holds_asked > holds_done) begin
        pause = HOLD_CYCLES;
        holds_done++;
      end else begin
        pause = calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic offer(input logic [2:0] op, input logic [15:0] edge_id,
                       input logic signed [31:0] dist_val, input logic [5:0] idx);
    int pause;
    pause = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_edge_id    <= edge_id;
    in_distance   <= dist_val;
    in_read_index <= idx;
    do @(posedge clk); while (!in_ready);
    if (op == OP_INSERT) begin
      recent_edges[recent_slot] = edge_id;
      recent_slot = (recent_slot + 1) % 16;
    end
  endtask

  task automatic offer_random(input int insert_pct);
    int                 roll;
    logic [2:0]         op;
    logic [15:0]        edge_id;
    logic signed [31:0] dist_val;
    logic [5:0]         idx;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) begin
      op = OP_INSERT;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 35)      op = OP_FIND;
      else if (roll < 50) op = OP_MERGE;
      else if (roll < 55) op = OP_CLEAR;
      else if (roll < 93) op = OP_READ;
      else                op = 3'($urandom_range(int'(OP_READ) + 1, int'(OP_CODE_TOP)));
    end
    edge_id = ($urandom_range(0, 1) == 1) ? recent_edges[$urandom_range(0, 15)]
                                          : 16'($urandom);
    // mostly clustered distances so that merges have neighbours to fold
    roll = $urandom_range(0, 99);
    if (roll < 60)      dist_val = cluster_base + 32'($urandom_range(0, 4000));
    else if (roll < 85) dist_val = $urandom;
    else if (roll < 90) dist_val = DIST_LOWEST;
    else if (roll < 95) dist_val = DIST_HIGHEST;
    else                dist_val = cluster_base;
    idx = ($urandom_range(0, 1) == 1) ? 6'($urandom) : 6'($urandom_range(0, 15));
    offer(op, edge_id, dist_val, idx);
  endtask

  // wait until every result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_gap(input logic [15:0] value);
    settle();
    cfg_valid     <= 1'b1;
    cfg_merge_gap <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         ph;
    int         n;
    int         insert_pct;
    logic [2:0] code;
    logic [15:0] gap_pick;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: read, merge and find, then the lowest and highest distances
    offer(OP_READ, '0, '0, '0);
    offer(OP_MERGE, '0, '0, '0);
    offer(OP_FIND, 16'hFFFF, '0, '0);
    offer(OP_INSERT, 16'h0000, DIST_LOWEST, '0);
    offer(OP_MERGE, '0, '0, '0);
    offer(OP_INSERT, 16'hFFFF, DIST_HIGHEST, 6'h3F);
    // equal distances keep arrival order; one entry exactly at the gap
    offer(OP_INSERT, 16'h0001, 32'sd0, '0);
    offer(OP_INSERT, 16'h0002, 32'sd0, '0);
    offer(OP_INSERT, 16'h0003, 32'(MERGE_GAP_RESET), '0);
    offer(OP_INSERT, 16'h0004, 32'sd1639, '0);
    offer(OP_FIND, 16'hFFFF, '0, '0);
    offer(OP_FIND, 16'h1234, '0, '0);
    offer(OP_READ, '0, '0, 6'd0);
    offer(OP_READ, '0, '0, 6'd2);
    offer(OP_READ, '0, '0, 6'h3F);
    for (code = OP_READ + 3'd1; code != OP_INSERT; code++)
      offer(code, 16'hFFFF, DIST_HIGHEST, 6'h3F);
    offer(OP_MERGE, '0, '0, '0);
    offer(OP_READ, '0, '0, 6'd1);
    offer(OP_READ, '0, '0, 6'd3);
    offer(OP_CLEAR, '0, '0, '0);
    offer(OP_READ, '0, '0, 6'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       gap_pick = GAP_NONE;
        1:       gap_pick = GAP_WIDEST;
        2:       gap_pick = MERGE_GAP_RESET;
        default: gap_pick = (ph % 2 == 1) ? 16'($urandom) : 16'($urandom_range(0, 4095));
      endcase
      set_gap(gap_pick);
      cluster_base = $urandom;
      calm         = (ph % 4 == 3);
      insert_pct   = (ph % 3 == 1) ? 85 : 50;
      if (ph == 1 || ph == 7) begin
        // run the table past full
        offer(OP_CLEAR, '0, '0, '0);
        for (n = 0; n < FILL_ITEMS; n++) offer_random(100);
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ((ph == 2 || ph == 6) && n == 30) holds_asked++;
        offer_random(insert_pct);
      end
    end

    calm = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
